/* design/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/mss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media signature sniffer package
// Shared types, signature tables and the brand lookup of the sniffer.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SNIFF_LIMIT = 512;
    localparam int COUNT_W = $clog2(SNIFF_LIMIT + 1);
    localparam int SIG_COUNT = 6;
    localparam int SIG_MAX = 12;

    typedef logic [3:0] media_type_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam media_type_t TYPE_NONE = 4'd0;
    localparam media_type_t TYPE_OGG = 4'd1;
    localparam media_type_t TYPE_WAV = 4'd2;
    localparam media_type_t TYPE_ID3 = 4'd3;
    localparam media_type_t TYPE_MIDI = 4'd4;
    localparam media_type_t TYPE_AMR = 4'd5;
    localparam media_type_t TYPE_MP4_VIDEO = 4'd6;
    localparam media_type_t TYPE_3GPP = 4'd7;
    localparam media_type_t TYPE_MP4_AUDIO = 4'd8;
    localparam media_type_t TYPE_QUICKTIME = 4'd9;

    localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{4'd5, 4'd12, 4'd3, 4'd8, 4'd8, 4'd6};

    localparam media_type_t SIG_TYPE [SIG_COUNT] =
        '{TYPE_OGG, TYPE_WAV, TYPE_ID3, TYPE_MIDI, TYPE_AMR, TYPE_AMR};

    localparam logic [7:0] SIG_PAT [SIG_COUNT][SIG_MAX] = '{
        '{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h57, 8'h41, 8'h56, 8'h45},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00,
          8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h2D,
          8'h57, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h0A,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] SIG_MASK [SIG_COUNT][SIG_MAX] = '{
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] FTYP_TEXT [4] = '{8'h66, 8'h74, 8'h79, 8'h70};

    // Result of the prefix signature stage, handed to the top level.
    typedef struct packed {
        logic [SIG_COUNT-1:0] alive;
        logic hit;
        media_type_t hit_type;
    } sig_status_t;

    function automatic media_type_t brand_lookup(input logic [31:0] word);
        media_type_t result;
        result = TYPE_NONE;
        if (word[31:8] == 24'h6D7034 || word[31:8] == 24'h617663) begin
            result = TYPE_MP4_VIDEO;
        end
        else if (word[31:8] == 24'h336770) begin
            result = TYPE_3GPP;
        end
        else if (word == 32'h4D344120 || word == 32'h4D345020) begin
            result = TYPE_MP4_AUDIO;
        end
        else if (word == 32'h71742020) begin
            result = TYPE_QUICKTIME;
        end
        return result;
    endfunction

endpackage

/* design/mss_prefix_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix signature matcher
// Updates the per-signature match flags for one word and picks the first
// signature in table order that is still matching over its full length.
// ----------------------------------------------------------------------------
module mss_prefix_match (
    input  mss_pkg::count_t                       byte_count,
    input  mss_pkg::count_t                       count_after,
    input  logic                                  consume,
    input  logic [7:0]                            data_byte,
    input  logic [mss_pkg::SIG_COUNT-1:0]         alive,
    output mss_pkg::sig_status_t                  status
);

    logic [3:0] idx;

    assign idx = byte_count[3:0];

    always_comb
    begin
        status.alive = alive;
        status.hit = 1'b0;
        status.hit_type = mss_pkg::TYPE_NONE;
        for (int i = 0; i < mss_pkg::SIG_COUNT; i++)
        begin
            if (consume && byte_count < mss_pkg::COUNT_W'(mss_pkg::SIG_LEN[i]))
            begin
                if ((mss_pkg::SIG_MASK[i][idx] & data_byte) != mss_pkg::SIG_PAT[i][idx])
                begin
                    status.alive[i] = 1'b0;
                end
            end
        end
        for (int i = mss_pkg::SIG_COUNT - 1; i >= 0; i--)
        begin
            if (status.alive[i] && count_after >= mss_pkg::COUNT_W'(mss_pkg::SIG_LEN[i]))
            begin
                status.hit = 1'b1;
                status.hit_type = mss_pkg::SIG_TYPE[i];
            end
        end
    end

endmodule

/* design/media_signature_sniffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media signature sniffer
// Identifies audio and video resources from their leading bytes.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle, each a byte of the resource from offset
// zero, and looks at no more than the first 512 of them. When the word marked
// last is taken, the media type appears on the result channel in the next
// cycle, and the unit starts over for a new resource. All checks for a word
// are done combinationally between the state registers and the result register,
// so the sustained rate is one word per cycle; data_ready drops only while a
// verdict sits in the result register and result_ready is low.
// ----------------------------------------------------------------------------
module media_signature_sniffer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  result_valid,
    input  logic                  result_ready,
    output mss_pkg::media_type_t  media_type
);

    mss_pkg::count_t                    byte_count_reg;
    mss_pkg::count_t                    byte_count_next;
    mss_pkg::count_t                    count_c;
    logic [mss_pkg::SIG_COUNT-1:0]      signature_alive_reg;
    logic [mss_pkg::SIG_COUNT-1:0]      signature_alive_next;
    logic [31:0]                        box_length_reg;
    logic [31:0]                        box_length_next;
    logic [31:0]                        box_c;
    logic                               ftyp_seen_reg;
    logic                               ftyp_seen_next;
    logic                               ftyp_c;
    logic [23:0]                        brand_window_reg;
    logic [23:0]                        brand_window_next;
    logic [23:0]                        window_c;
    mss_pkg::media_type_t               brand_type_reg;
    mss_pkg::media_type_t               brand_type_next;
    mss_pkg::media_type_t               brand_c;
    logic                               result_valid_reg;
    logic                               result_valid_next;
    mss_pkg::media_type_t               media_type_reg;
    mss_pkg::media_type_t               media_type_next;
    mss_pkg::media_type_t               verdict;
    mss_pkg::sig_status_t               sig_status;
    logic                               consume;
    logic                               accept;
    logic                               at_word;
    logic                               box_ok;

    assign accept = data_valid && data_ready;
    assign consume = byte_count_reg < mss_pkg::COUNT_W'(mss_pkg::SNIFF_LIMIT);

    mss_prefix_match u_prefix_match (
        .byte_count  (byte_count_reg),
        .count_after (count_c),
        .consume     (consume),
        .data_byte   (data_byte),
        .alive       (signature_alive_reg),
        .status      (sig_status)
    );

    always_comb
    begin
        count_c = byte_count_reg;
        box_c = box_length_reg;
        ftyp_c = ftyp_seen_reg;
        window_c = brand_window_reg;
        brand_c = brand_type_reg;
        at_word = (byte_count_reg == mss_pkg::COUNT_W'(11)) ||
                  (byte_count_reg >= mss_pkg::COUNT_W'(19) && byte_count_reg[1:0] == 2'b11 &&
                   (32'(byte_count_reg) - 32'd3) < box_length_reg);
        if (consume)
        begin
            count_c = byte_count_reg + mss_pkg::COUNT_W'(1);
            window_c = {brand_window_reg[15:0], data_byte};
            if (byte_count_reg < mss_pkg::COUNT_W'(4))
            begin
                box_c = {box_length_reg[23:0], data_byte};
            end
            else if (byte_count_reg < mss_pkg::COUNT_W'(8) &&
                     data_byte != mss_pkg::FTYP_TEXT[byte_count_reg[1:0]])
            begin
                ftyp_c = 1'b0;
            end
            if (brand_type_reg == mss_pkg::TYPE_NONE && at_word)
            begin
                brand_c = mss_pkg::brand_lookup({brand_window_reg, data_byte});
            end
        end
    end

    assign box_ok = count_c > mss_pkg::COUNT_W'(12) && box_c[1:0] == 2'b00 &&
                    box_c <= 32'(count_c) && ftyp_c && brand_c != mss_pkg::TYPE_NONE;

    always_comb
    begin
        if (sig_status.hit)
        begin
            verdict = sig_status.hit_type;
        end
        else if (box_ok)
        begin
            verdict = brand_c;
        end
        else
        begin
            verdict = mss_pkg::TYPE_NONE;
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        signature_alive_next = signature_alive_reg;
        box_length_next = box_length_reg;
        ftyp_seen_next = ftyp_seen_reg;
        brand_window_next = brand_window_reg;
        brand_type_next = brand_type_reg;
        media_type_next = media_type_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (accept)
        begin
            if (last_byte)
            begin
                byte_count_next = '0;
                signature_alive_next = '1;
                box_length_next = '0;
                ftyp_seen_next = 1'b1;
                brand_window_next = '0;
                brand_type_next = mss_pkg::TYPE_NONE;
                media_type_next = verdict;
                result_valid_next = 1'b1;
            end
            else
            begin
                byte_count_next = count_c;
                signature_alive_next = sig_status.alive;
                box_length_next = box_c;
                ftyp_seen_next = ftyp_c;
                brand_window_next = window_c;
                brand_type_next = brand_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            signature_alive_reg <= '1;
            box_length_reg <= '0;
            ftyp_seen_reg <= 1'b1;
            brand_window_reg <= '0;
            brand_type_reg <= mss_pkg::TYPE_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            signature_alive_reg <= signature_alive_next;
            box_length_reg <= box_length_next;
            ftyp_seen_reg <= ftyp_seen_next;
            brand_window_reg <= brand_window_next;
            brand_type_reg <= brand_type_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        media_type_reg <= media_type_next;
    end

    assign data_ready = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign media_type = media_type_reg;

endmodule

/* design/mss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media signature sniffer port checker
// Watches the ports of the sniffer and checks the word flow over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mss_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    input  logic                  data_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  mss_pkg::media_type_t  media_type
);

    logic last_taken;

    assign last_taken = data_valid && data_ready && last_byte;

    `ASSERT_NEXT(a_verdict_follows_last, last_taken,
        result_valid && media_type <= mss_pkg::TYPE_QUICKTIME)
    `ASSERT_SAME(a_verdict_has_cause, $rose(result_valid), $past(last_taken))
    `ASSERT_SAME(a_no_overrun, result_valid && !result_ready, !data_ready)
    `ASSERT_NEXT(a_input_holds, data_valid && !data_ready,
        data_valid && $stable(data_byte) && $stable(last_byte))
    `ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
        result_valid && $stable(media_type))

endmodule

bind media_signature_sniffer_unit mss_checker u_mss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .media_type   (media_type)
);
